// ===== hw/rtl/rzs_pkg.sv =====
`default_nettype none
package rzs_pkg;

  localparam int SymbolsDef   = 64;
  localparam int WindowDef    = 64;
  localparam int PriceBitsDef = 24;

  localparam int SymIdW   = 6;
  localparam int PriceW   = 24;
  localparam int QtyW     = 32;
  localparam int PosW     = 32;
  localparam int ThrW     = 12;
  localparam int EqtyW    = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [ThrW-1:0]  EntryThrRst = 12'd512;
  localparam logic [ThrW-1:0]  ExitThrRst  = 12'd128;
  localparam logic [EqtyW-1:0] EntryQtyRst = 16'd1;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_FILL   = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENTRY_THR = 2'd0,
    CFG_EXIT_THR  = 2'd1,
    CFG_ENTRY_QTY = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WIN,
    ST_UPD,
    ST_VAR1,
    ST_VAR2,
    ST_MUL,
    ST_CMP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr;
    logic accept;
    logic load_state;
    logic fill_wr;
    logic sq;
    logic upd;
    logic var1;
    logic var2;
    logic mul;
    logic cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic in_range;
    logic is_fill;
    logic full;
    logic emit;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rzs_if.sv =====
`default_nettype none
interface rzs_in_if import rzs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [SymIdW-1:0] symbol_id;
  logic [PriceW-1:0] bid_price;
  logic [PriceW-1:0] ask_price;
  logic              fill_side;
  logic [QtyW-1:0]   fill_quantity;

  modport source (output valid, opcode, symbol_id, bid_price, ask_price, fill_side,
                  fill_quantity, input ready);
  modport sink (input valid, opcode, symbol_id, bid_price, ask_price, fill_side,
                fill_quantity, output ready);
endinterface

interface rzs_out_if import rzs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              order_side;
  logic [SymIdW-1:0] order_symbol;
  logic [PriceW-1:0] order_price;
  logic [QtyW-1:0]   order_quantity;

  modport source (output valid, order_side, order_symbol, order_price, order_quantity,
                  input ready);
  modport sink (input valid, order_side, order_symbol, order_price, order_quantity,
                output ready);
endinterface

interface rzs_cfg_if import rzs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rolling_zscore_signal.sv =====
`default_nettype none
// channel  | dir | payload
// in_i     | in  | opcode, symbol_id, bid_price, ask_price, fill_side, fill_quantity
// out_o    | out | order_side, order_symbol, order_price, order_quantity
// cfg_i    | in  | index, data (always ready)
//
// One transaction at a time. A fill is read and written back; a tick on a filling
// window goes through read, window read and update; a tick on a full window adds
// two variance steps, split threshold products, compare and result load, limited
// by the multiply chain. After reset a clearing pass zeroes the per-symbol state RAM.
// A result waits in the output register; a later result waits for it to drain.
module rolling_zscore_signal import rzs_pkg::*; #(
  parameter int SYMBOLS    = SymbolsDef,
  parameter int WINDOW     = WindowDef,
  parameter int PRICE_BITS = PriceBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rzs_in_if.sink    in_i,
  rzs_out_if.source out_o,
  rzs_cfg_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;

  rzs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rzs_dp #(
    .SYMBOLS    (SYMBOLS),
    .WINDOW     (WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rzs_ram.sv =====
`default_nettype none
module rzs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rzs_ctrl.sv =====
`default_nettype none
module rzs_ctrl import rzs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.accept = 1'b1;
        if (sts_i.in_valid && sts_i.in_range) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.load_state = 1'b1;
        if (sts_i.is_fill) begin
          cmd_o.fill_wr = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          state_d = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd_o.sq = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = sts_i.full ? ST_VAR1 : ST_IDLE;
      end
      ST_VAR1: begin
        cmd_o.var1 = 1'b1;
        state_d    = ST_VAR2;
      end
      ST_VAR2: begin
        cmd_o.var2 = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.emit) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rzs_dp.sv =====
`default_nettype none
module rzs_dp import rzs_pkg::*; #(
  parameter int SYMBOLS    = SymbolsDef,
  parameter int WINDOW     = WindowDef,
  parameter int PRICE_BITS = PriceBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  output      sts_t  sts_o,
  rzs_in_if.sink     in_i,
  rzs_out_if.source  out_o,
  rzs_cfg_if.sink    cfg_i
);

  localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int MID_W  = PRICE_BITS + 1;
  localparam int SUM_W  = MID_W + SLOT_W;
  localparam int SQ_W   = 2 * MID_W + SLOT_W;
  localparam int VW     = SQ_W + SLOT_W;
  localparam int VLO_W  = VW / 2;
  localparam int VHI_W  = VW - VLO_W;
  localparam int TT_W   = 2 * ThrW;
  localparam int CW     = VW + TT_W;
  localparam int WIN_DEPTH = (2 ** SYM_W) * (2 ** SLOT_W);

  typedef struct packed {
    logic [SLOT_W-1:0]      slot;
    logic [FILL_W-1:0]      fill;
    logic [SUM_W-1:0]       sum;
    logic [SQ_W-1:0]        sq;
    logic signed [PosW-1:0] pos;
  } sym_st_t;

  // configuration
  logic [ThrW-1:0]  entry_thr_q, exit_thr_q;
  logic [EqtyW-1:0] entry_qty_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_thr_q <= EntryThrRst;
      exit_thr_q  <= ExitThrRst;
      entry_qty_q <= EntryQtyRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ENTRY_THR: entry_thr_q <= cfg_i.data[ThrW-1:0];
        CFG_EXIT_THR:  exit_thr_q  <= cfg_i.data[ThrW-1:0];
        CFG_ENTRY_QTY: entry_qty_q <= cfg_i.data[EqtyW-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic [SYM_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // item capture
  logic                  take;
  logic                  op_q;
  logic [SymIdW-1:0]     sym_raw_q;
  logic [PRICE_BITS-1:0] bid_q, ask_q;
  logic                  fside_q;
  logic [QtyW-1:0]       fqty_q;
  logic [SYM_W-1:0]      sym_idx;
  logic [MID_W-1:0]      mid;

  assign in_i.ready = cmd_i.accept;
  assign take       = cmd_i.accept && in_i.valid;
  assign sym_idx    = SYM_W'(sym_raw_q);
  assign mid        = MID_W'(bid_q) + MID_W'(ask_q);

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q      <= in_i.opcode;
      sym_raw_q <= in_i.symbol_id;
      bid_q     <= in_i.bid_price[PRICE_BITS-1:0];
      ask_q     <= in_i.ask_price[PRICE_BITS-1:0];
      fside_q   <= in_i.fill_side;
      fqty_q    <= in_i.fill_quantity;
    end
  end

  // memories
  sym_st_t          st_rd, st_q, st_wr;
  logic             st_we;
  logic [SYM_W-1:0] st_waddr;
  logic [MID_W-1:0] old_rd;

  rzs_ram #(.WIDTH($bits(sym_st_t)), .DEPTH(SYMBOLS)) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wr),
    .raddr_i (SYM_W'(in_i.symbol_id)),
    .rdata_o (st_rd)
  );

  rzs_ram #(.WIDTH(MID_W), .DEPTH(WIN_DEPTH)) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i ({sym_idx, st_q.slot}),
    .wdata_i (mid),
    .raddr_i ({sym_idx, st_rd.slot}),
    .rdata_o (old_rd)
  );

  // fill update
  logic signed [PosW+1:0] pos_sum;
  logic signed [PosW-1:0] pos_new;

  always_comb begin
    if (fside_q == SIDE_SELL) begin
      pos_sum = (PosW+2)'(st_rd.pos) - $signed({2'b00, fqty_q});
    end else begin
      pos_sum = (PosW+2)'(st_rd.pos) + $signed({2'b00, fqty_q});
    end
    if (pos_sum > $signed({3'b000, {(PosW-1){1'b1}}})) begin
      pos_new = {1'b0, {(PosW-1){1'b1}}};
    end else if (pos_sum < $signed({3'b111, {(PosW-1){1'b0}}})) begin
      pos_new = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      pos_new = pos_sum[PosW-1:0];
    end
  end

  // window update
  logic [MID_W-1:0]   old_q;
  logic [2*MID_W-1:0] old_sq_q, mid_sq_q;
  logic               was_full;
  logic [SUM_W-1:0]   sum_n;
  logic [SQ_W-1:0]    sq_n;
  sym_st_t            st_upd;

  assign was_full = (st_q.fill == FILL_W'(WINDOW));

  always_comb begin
    sum_n = st_q.sum + SUM_W'(mid);
    sq_n  = st_q.sq + SQ_W'(mid_sq_q);
    if (was_full) begin
      sum_n = sum_n - SUM_W'(old_q);
      sq_n  = sq_n - SQ_W'(old_sq_q);
    end
    st_upd      = st_q;
    st_upd.sum  = sum_n;
    st_upd.sq   = sq_n;
    st_upd.slot = (st_q.slot == SLOT_W'(WINDOW - 1)) ? '0 : st_q.slot + 1'b1;
    st_upd.fill = was_full ? st_q.fill : st_q.fill + 1'b1;
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = sym_idx;
    st_wr    = st_upd;
    if (cmd_i.clr) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt_q;
      st_wr    = '0;
    end else if (cmd_i.fill_wr) begin
      st_we     = 1'b1;
      st_wr     = st_rd;
      st_wr.pos = pos_new;
    end else if (cmd_i.upd) begin
      st_we = 1'b1;
    end
  end

  // statistics pipeline
  logic [SUM_W-1:0]       s_q, dev_q;
  logic [SQ_W-1:0]        q_q;
  logic                   up_q, vz_q;
  logic [VW-1:0]          ss_q, wq_q, v_q, dd_q;
  logic [TT_W-1:0]        e2_q, x2_q;
  logic [VLO_W+TT_W-1:0]  pel_q, pxl_q;
  logic [VHI_W+TT_W-1:0]  peh_q, pxh_q;
  logic [SUM_W-1:0]       wm;

  assign wm = SUM_W'(mid) * SUM_W'(WINDOW);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_state) begin
      st_q <= st_rd;
    end
    if (cmd_i.sq) begin
      old_q    <= old_rd;
      old_sq_q <= (2*MID_W)'(old_rd) * (2*MID_W)'(old_rd);
      mid_sq_q <= (2*MID_W)'(mid) * (2*MID_W)'(mid);
    end
    if (cmd_i.upd) begin
      s_q <= sum_n;
      q_q <= sq_n;
    end
    if (cmd_i.var1) begin
      ss_q  <= VW'(s_q) * VW'(s_q);
      wq_q  <= VW'(q_q) * VW'(WINDOW);
      up_q  <= (wm >= s_q);
      dev_q <= (wm >= s_q) ? wm - s_q : s_q - wm;
      e2_q  <= TT_W'(entry_thr_q) * TT_W'(entry_thr_q);
      x2_q  <= TT_W'(exit_thr_q) * TT_W'(exit_thr_q);
    end
    if (cmd_i.var2) begin
      v_q  <= wq_q - ss_q;
      dd_q <= VW'(dev_q) * VW'(dev_q);
    end
    if (cmd_i.mul) begin
      vz_q  <= (v_q == '0);
      pel_q <= (VLO_W+TT_W)'(v_q[VLO_W-1:0]) * (VLO_W+TT_W)'(e2_q);
      peh_q <= (VHI_W+TT_W)'(v_q[VW-1:VLO_W]) * (VHI_W+TT_W)'(e2_q);
      pxl_q <= (VLO_W+TT_W)'(v_q[VLO_W-1:0]) * (VLO_W+TT_W)'(x2_q);
      pxh_q <= (VHI_W+TT_W)'(v_q[VW-1:VLO_W]) * (VHI_W+TT_W)'(x2_q);
    end
  end

  // decision
  logic [CW-1:0]         ent, ext, lhs;
  logic                  emit_d, side_d;
  logic [PRICE_BITS-1:0] price_d;
  logic [QtyW-1:0]       qty_d;
  logic                  emit_q, side_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [QtyW-1:0]       qty_q;

  assign ent = (CW'(peh_q) << VLO_W) + CW'(pel_q);
  assign ext = (CW'(pxh_q) << VLO_W) + CW'(pxl_q);
  assign lhs = CW'(dd_q) << 16;

  always_comb begin
    emit_d  = 1'b0;
    side_d  = SIDE_BUY;
    price_d = ask_q;
    qty_d   = QtyW'(entry_qty_q);
    if (st_q.pos == '0) begin
      emit_d = !vz_q && (lhs >= ent);
      if (up_q) begin
        side_d  = SIDE_SELL;
        price_d = bid_q;
      end
    end else begin
      emit_d = !vz_q && (lhs <= ext);
      if (st_q.pos[PosW-1]) begin
        qty_d = QtyW'(-st_q.pos);
      end else begin
        side_d  = SIDE_SELL;
        price_d = bid_q;
        qty_d   = QtyW'(st_q.pos);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      side_q  <= side_d;
      price_q <= price_d;
      qty_q   <= qty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      emit_q <= emit_d;
    end
  end

  // output register
  logic                  out_valid_q;
  logic                  out_side_q;
  logic [SymIdW-1:0]     out_sym_q;
  logic [PRICE_BITS-1:0] out_price_q;
  logic [QtyW-1:0]       out_qty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_side_q  <= side_q;
      out_sym_q   <= sym_raw_q;
      out_price_q <= price_q;
      out_qty_q   <= qty_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.order_side     = out_side_q;
  assign out_o.order_symbol   = out_sym_q;
  assign out_o.order_price    = PriceW'(out_price_q);
  assign out_o.order_quantity = out_qty_q;

  // status
  assign sts_o.clr_last = (clr_cnt_q == SYM_W'(SYMBOLS - 1));
  assign sts_o.in_valid = in_i.valid;
  assign sts_o.in_range = (32'(in_i.symbol_id) < 32'(SYMBOLS));
  assign sts_o.is_fill  = (op_q == OP_FILL);
  assign sts_o.full     = (st_upd.fill == FILL_W'(WINDOW));
  assign sts_o.emit     = emit_q;
  assign sts_o.out_free = !out_valid_q || out_o.ready;

endmodule
`default_nettype wire
